// ----- rtl/core/pate_pkg.sv -----
package pate_pkg;

    // Field widths of the request and result transfers.
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    localparam int TABLE_DEPTH_DEFAULT = 64;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [VALUE_W-1:0]  word_t;

    // Request kinds.
    localparam kind_t KIND_SEARCH = 2'd0;
    localparam kind_t KIND_MODIFY = 2'd1;
    localparam kind_t KIND_APPEND = 2'd2;
    localparam kind_t KIND_REMOVE = 2'd3;

    // Result status codes.
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;
    localparam status_t STATUS_RANGE     = 2'd3;

endpackage

// ----- rtl/core/pate_ram.sv -----
module pate_ram #(
    parameter int WIDTH = pate_pkg::VALUE_W,
    parameter int DEPTH = pate_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port; read data is registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/packed_array_table_engine.sv -----
// Packed table engine: holds up to TABLE_DEPTH signed 32-bit entries kept packed
// at the low end of a single-port-read table, plus a live count that resets to zero.
// Each request transfer is a search (lowest index holding the value), a modify
// (write at an index, old value returned), an append, or a remove (entry deleted and
// later entries shifted down one place), and each one yields exactly one result
// transfer carrying a status and the live count after the request. Refused requests
// (append on a full table, modify or remove at an index not below the count) leave
// the table untouched. The block takes one request at a time and holds in_stall
// high until that request is finished. Append, any refused request and a search of
// an empty table go from the accepting edge straight to the finish step, which loads
// the result into the output register; modify, search and remove first walk the
// table: modify reads its one entry and then writes the new value, a search reads
// from entry 0 until a hit or the last entry, and a remove at index i reads from i to
// the last entry. The walk reads one entry per cycle through the single memory read
// port; a search checks each against the key with one shared comparator, and remove
// writes each entry back one place lower as it streams by. The output register lets
// the next request be accepted while the previous result still waits to be taken.
module packed_array_table_engine #(
    parameter int TABLE_DEPTH = pate_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  pate_pkg::kind_t                   kind,
    input  logic [pate_pkg::INDEX_W-1:0]      index,
    input  logic signed [pate_pkg::VALUE_W-1:0] value,

    output logic                              out_valid,
    input  logic                              out_stall,
    output pate_pkg::status_t                 status,
    output logic [pate_pkg::INDEX_W-1:0]      found_index,
    output logic signed [pate_pkg::VALUE_W-1:0] old_value,
    output logic [pate_pkg::TOTAL_W-1:0]      entry_total
);

    // AW addresses the table, CW holds a count up to and including the depth.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = pate_pkg::INDEX_W;
    localparam int TW = pate_pkg::TOTAL_W;
    localparam int XW = (CW > IW) ? CW : IW;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]              state_reg, state_next;
    pate_pkg::kind_t         kind_reg, kind_next;
    pate_pkg::word_t         key_reg, key_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           last_reg, last_next;
    logic [CW-1:0]           addr_reg, addr_next;
    logic                    issue_reg, issue_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [CW-1:0]           rd_idx_reg, rd_idx_next;
    logic [CW-1:0]           count_reg, count_next;
    pate_pkg::status_t       res_status_reg, res_status_next;
    logic [IW-1:0]           res_found_reg, res_found_next;
    pate_pkg::word_t         res_old_reg, res_old_next;

    logic                    out_valid_reg, out_valid_next;
    pate_pkg::status_t       out_status_reg;
    logic [IW-1:0]           out_found_reg;
    pate_pkg::word_t         out_old_reg;
    logic [TW-1:0]           out_total_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    pate_pkg::word_t         ram_wdata;
    logic [AW-1:0]           ram_raddr;
    pate_pkg::word_t         ram_rdata;

    logic                    out_free;
    logic                    load_out;
    logic                    key_match;
    logic                    in_range;

    pate_ram #(
        .WIDTH (pate_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register is free when empty or when its result leaves this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == S_FIN) && out_free;
    assign in_stall  = (state_reg != S_IDLE);

    // The one comparator shared by every step of a search.
    assign key_match = (ram_rdata == key_reg);

    // Range check done at the wider of the two widths so no index bits are lost.
    assign in_range  = (XW'(index) < XW'(count_reg));

    assign ram_raddr = addr_reg[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_old_next    = res_old_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg[AW-1:0];
        ram_wdata       = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = kind;
                    key_next        = value;
                    idx_next        = CW'(index);
                    res_status_next = pate_pkg::STATUS_OK;
                    res_found_next  = '0;
                    res_old_next    = '0;
                    state_next      = S_FIN;
                    unique case (kind)
                        pate_pkg::KIND_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = pate_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                addr_next  = '0;
                                last_next  = count_reg - ONE;
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        pate_pkg::KIND_MODIFY:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = pate_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                addr_next  = CW'(index);
                                last_next  = CW'(index);
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        pate_pkg::KIND_APPEND:
                        begin
                            if (count_reg >= FULL_COUNT)
                            begin
                                res_status_next = pate_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = value;
                                count_next = count_reg + ONE;
                            end
                        end
                        pate_pkg::KIND_REMOVE:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = pate_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                addr_next  = CW'(index);
                                last_next  = count_reg - ONE;
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Read side: one entry per cycle up to the last one needed.
                if (issue_reg)
                begin
                    addr_next    = addr_reg + ONE;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = addr_reg;
                    if (addr_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                end

                // Data side: the entry read in the previous cycle.
                if (rd_pend_reg)
                begin
                    unique case (kind_reg)
                        pate_pkg::KIND_SEARCH:
                        begin
                            if (key_match)
                            begin
                                res_found_next = IW'(rd_idx_reg);
                                state_next     = S_FIN;
                            end
                            else if (rd_idx_reg == last_reg)
                            begin
                                res_status_next = pate_pkg::STATUS_NOT_FOUND;
                                state_next      = S_FIN;
                            end
                        end
                        pate_pkg::KIND_MODIFY:
                        begin
                            res_old_next = ram_rdata;
                            ram_we       = 1'b1;
                            ram_waddr    = rd_idx_reg[AW-1:0];
                            ram_wdata    = key_reg;
                            state_next   = S_FIN;
                        end
                        pate_pkg::KIND_REMOVE:
                        begin
                            if (rd_idx_reg == idx_reg)
                            begin
                                res_old_next = ram_rdata;
                            end
                            else
                            begin
                                // Move this entry one place down.
                                ram_we    = 1'b1;
                                ram_waddr = AW'(rd_idx_reg - ONE);
                                ram_wdata = ram_rdata;
                            end
                            if (rd_idx_reg == last_reg)
                            begin
                                count_next = count_reg - ONE;
                                state_next = S_FIN;
                            end
                        end
                        pate_pkg::KIND_APPEND:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end

                // Drop any reads still in flight once the walk ends.
                if (state_next != S_SCAN)
                begin
                    issue_next   = 1'b0;
                    rd_pend_next = 1'b0;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            rd_pend_reg   <= rd_pend_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        last_reg       <= last_next;
        addr_reg       <= addr_next;
        rd_idx_reg     <= rd_idx_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_old_reg    <= res_old_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_old_reg    <= res_old_reg;
            out_total_reg  <= TW'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_index = out_found_reg;
    assign old_value   = out_old_reg;
    assign entry_total = out_total_reg;

    // The live count never exceeds the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("live count exceeds table depth");

    // Taking a request always raises in_stall, so the next request must wait.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while the previous one is in progress");

    // The only table write while idle is an append.
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_IDLE) |-> (in_valid && kind == pate_pkg::KIND_APPEND))
        else $error("table written while idle by something other than an append");

    // A new result only appears after the finish step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result loaded outside the finish step");

endmodule
